// ===== src/ecsr_pkg.sv =====
// Shared types and constants for the edge-list to CSR builder.
package ecsr_pkg;

    localparam int MODE_W    = 2;
    localparam int VID_W     = 10;
    localparam int ADDR_W    = 13;
    localparam int VALUE_W   = 13;
    localparam int STATUS_W  = 2;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_BUILD = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_ID_RANGE = 2'd1,
        STAT_OVERFLOW = 2'd2,
        STAT_BAD_READ = 2'd3
    } t_status;

    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Register index of max_vertex_id, taken from the word address bit.
    localparam logic REG_MAX_ID = 1'b0;

    localparam logic [VID_W-1:0] MAX_ID_RESET = 10'd1023;

endpackage

// ===== src/edge_list_to_csr_builder_top.sv =====
// Top level of the edge-list to CSR builder: sequencer, shared adder and memories.
//
// Usage: a command word is taken on start while busy is low. i_mode selects
// clear, add edge, build or read of one CSR image word. Build and read each give
// one result word on o_result_kind/o_status/o_value, marked by o_result_valid for
// exactly one cycle; the receiver cannot stall, so the word must be taken then.
// Clear and add give no result: busy stays low and the next
// command may follow at once. A read raises busy for one cycle; its result passes
// through the offset or target memory read register, then the result register.
// A build walks the tables with one shared adder over one offset memory: zero the
// offsets, count degrees, prefix sum over m+3 slots, scatter targets, with the
// report in the first cycle that busy is low again.
// m is min(max_vertex_id, MAX_VERTICES-1).
// max_vertex_id sits at APB byte address 0; write it only while idle. A write
// invalidates the built image. Reset returns max_vertex_id to 1023 and empties
// the edge list, error flags and image; the memories need no clearing pass.
module edge_list_to_csr_builder_top #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ecsr_pkg::MODE_W-1:0]    i_mode,
    input  logic [ecsr_pkg::VID_W-1:0]     i_source_vertex,
    input  logic [ecsr_pkg::VID_W-1:0]     i_target_vertex,
    input  logic [ecsr_pkg::ADDR_W-1:0]    i_read_address,
    output logic                           o_result_valid,
    output logic                           o_result_kind,
    output logic [ecsr_pkg::STATUS_W-1:0]  o_status,
    output logic [ecsr_pkg::VALUE_W-1:0]   o_value,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ecsr_pkg::PADDR_W-1:0]   paddr,
    input  logic [ecsr_pkg::PDATA_W-1:0]   pwdata,
    output logic [ecsr_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import ecsr_pkg::*;

    // Vertex ids are 10 bits, so no more than 1024 vertices are reachable.
    localparam int VCAP      = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;
    // Degrees are counted at s+2 so the scatter leaves start offsets in place.
    localparam int OFF_DEPTH = VCAP + 2;
    localparam int OW        = $clog2(OFF_DEPTH);
    localparam int EW        = $clog2(MAX_EDGES + 1);
    localparam int AW        = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int KW        = (EW > ADDR_W) ? EW : ADDR_W;
    localparam logic [VID_W-1:0] VLIM = VID_W'(VCAP - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_ZERO,
        ST_CNT_A,
        ST_CNT_B,
        ST_CNT_C,
        ST_PFX_A,
        ST_PFX_B,
        ST_SCT_A,
        ST_SCT_B,
        ST_SCT_C
    } t_state;

    // Control and status
    t_state                r_state, n_state;
    logic [VID_W-1:0]      r_max_id, n_max_id;
    logic [EW-1:0]         r_edge_cnt, n_edge_cnt;
    logic [1:0]            r_err, n_err;
    logic                  r_built, n_built;
    logic [EW-1:0]         r_idx, n_idx;
    logic [OW-1:0]         r_vidx, n_vidx;
    logic [OW-1:0]         r_slot, n_slot;
    logic [VID_W-1:0]      r_tgt, n_tgt;
    logic [EW-1:0]         r_acc, n_acc;
    logic [EW-1:0]         r_total, n_total;
    logic                  r_rd_ok, n_rd_ok;
    logic                  r_rd_off, n_rd_off;
    logic                  r_valid, n_valid;
    logic                  r_kind, n_kind;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [VALUE_W-1:0]    r_value, n_value;

    // Memories and their ports
    logic [EW-1:0]          r_off_mem [OFF_DEPTH];
    logic [2*VID_W-1:0]     r_edge_mem [MAX_EDGES];
    logic [VID_W-1:0]       r_adj_mem [MAX_EDGES];
    logic [EW-1:0]          r_off_rdata;
    logic [2*VID_W-1:0]     r_edge_rdata;
    logic [VID_W-1:0]       r_adj_rdata;

    logic                   off_we;
    logic [OW-1:0]          off_waddr, off_raddr;
    logic [EW-1:0]          off_wdata;
    logic                   edge_we;
    logic [AW-1:0]          edge_waddr, edge_raddr;
    logic [2*VID_W-1:0]     edge_wdata;
    logic                   adj_we;
    logic [AW-1:0]          adj_waddr, adj_raddr;
    logic [VID_W-1:0]       adj_wdata;

    // Shared adder
    logic [EW-1:0]          add_a, add_b, add_sum;

    logic [VID_W-1:0]       m_eff;
    logic [OW-1:0]          m_p2;
    logic [ADDR_W-1:0]      img_m_p1, rd_k;
    logic                   rd_is_off;
    logic [VID_W-1:0]       st_src, st_tgt;
    logic                   st_out;
    logic                   cfg_wr;

    assign m_eff    = (r_max_id > VLIM) ? VLIM : r_max_id;
    assign m_p2     = OW'(m_eff) + OW'(2);
    assign img_m_p1 = ADDR_W'(m_eff) + ADDR_W'(1);
    assign rd_is_off = (i_read_address <= img_m_p1);
    // Target word index past the offset words; only used when above them.
    assign rd_k     = i_read_address - (img_m_p1 + ADDR_W'(1));

    assign st_src   = r_edge_rdata[2*VID_W-1:VID_W];
    assign st_tgt   = r_edge_rdata[VID_W-1:0];
    assign st_out   = (st_src > m_eff) || (st_tgt > m_eff);

    assign add_sum  = add_a + add_b;
    assign cfg_wr   = psel && penable && pwrite;

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_valid;
    assign o_result_kind  = r_kind;
    assign o_status       = r_status;
    assign o_value        = r_value;
    assign pready         = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_ID) ? PDATA_W'(r_max_id) : '0;

    always_comb begin
        n_state    = r_state;
        n_max_id   = r_max_id;
        n_edge_cnt = r_edge_cnt;
        n_err      = r_err;
        n_built    = r_built;
        n_idx      = r_idx;
        n_vidx     = r_vidx;
        n_slot     = r_slot;
        n_tgt      = r_tgt;
        n_acc      = r_acc;
        n_total    = r_total;
        n_rd_ok    = r_rd_ok;
        n_rd_off   = r_rd_off;
        n_valid    = 1'b0;
        n_kind     = r_kind;
        n_status   = r_status;
        n_value    = r_value;

        off_we     = 1'b0;
        off_waddr  = r_slot;
        off_wdata  = add_sum;
        off_raddr  = '0;
        edge_we    = 1'b0;
        edge_waddr = AW'(r_edge_cnt);
        edge_wdata = {i_source_vertex, i_target_vertex};
        edge_raddr = AW'(r_idx);
        adj_we     = 1'b0;
        adj_waddr  = AW'(r_off_rdata);
        adj_wdata  = r_tgt;
        adj_raddr  = '0;
        add_a      = r_off_rdata;
        add_b      = EW'(1);

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (t_mode'(i_mode))
                        MODE_CLEAR: begin
                            n_edge_cnt = '0;
                            n_err      = '0;
                            n_built    = 1'b0;
                        end
                        MODE_ADD: begin
                            if ((i_source_vertex > m_eff) || (i_target_vertex > m_eff)) begin
                                n_err[0] = 1'b1;
                            end else if (r_edge_cnt == EW'(MAX_EDGES)) begin
                                n_err[1] = 1'b1;
                            end else begin
                                edge_we    = 1'b1;
                                add_a      = r_edge_cnt;
                                n_edge_cnt = add_sum;
                                n_built    = 1'b0;
                            end
                        end
                        MODE_BUILD: begin
                            n_vidx  = '0;
                            n_state = ST_ZERO;
                        end
                        MODE_READ: begin
                            n_rd_off = rd_is_off;
                            n_rd_ok  = r_built &&
                                       (rd_is_off || (KW'(rd_k) < KW'(r_total)));
                            if (rd_is_off) begin
                                off_raddr = OW'(i_read_address);
                            end else begin
                                adj_raddr = AW'(rd_k);
                            end
                            n_state = ST_READ;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_valid = 1'b1;
                n_kind  = KIND_READ;
                if (!r_rd_ok) begin
                    n_status = STAT_BAD_READ;
                    n_value  = '0;
                end else if (r_rd_off) begin
                    n_status = STAT_OK;
                    n_value  = VALUE_W'(r_off_rdata);
                end else begin
                    n_status = STAT_OK;
                    n_value  = VALUE_W'(r_adj_rdata);
                end
                n_state = ST_IDLE;
            end
            ST_ZERO: begin
                // Clear the offsets up to the slot of the top vertex's count.
                off_we    = 1'b1;
                off_waddr = r_vidx;
                off_wdata = '0;
                if (r_vidx == m_p2) begin
                    n_idx   = '0;
                    n_state = ST_CNT_A;
                end else begin
                    n_vidx = r_vidx + OW'(1);
                end
            end
            ST_CNT_A: begin
                if (r_idx == r_edge_cnt) begin
                    n_vidx  = '0;
                    n_acc   = '0;
                    n_state = ST_PFX_A;
                end else begin
                    n_state = ST_CNT_B;
                end
            end
            ST_CNT_B: begin
                if (st_out) begin
                    n_err[0] = 1'b1;
                    n_idx    = r_idx + EW'(1);
                    n_state  = ST_CNT_A;
                end else begin
                    off_raddr = OW'(st_src) + OW'(2);
                    n_slot    = OW'(st_src) + OW'(2);
                    n_state   = ST_CNT_C;
                end
            end
            ST_CNT_C: begin
                off_we  = 1'b1;
                n_idx   = r_idx + EW'(1);
                n_state = ST_CNT_A;
            end
            ST_PFX_A: begin
                off_raddr = r_vidx;
                n_state   = ST_PFX_B;
            end
            ST_PFX_B: begin
                // Run the sum through the top vertex's count slot to get the total.
                add_a     = r_acc;
                add_b     = r_off_rdata;
                off_we    = 1'b1;
                off_waddr = r_vidx;
                n_acc     = add_sum;
                if (r_vidx == m_p2) begin
                    n_total = add_sum;
                    n_idx   = '0;
                    n_state = ST_SCT_A;
                end else begin
                    n_vidx  = r_vidx + OW'(1);
                    n_state = ST_PFX_A;
                end
            end
            ST_SCT_A: begin
                if (r_idx == r_edge_cnt) begin
                    n_built = 1'b1;
                    n_valid = 1'b1;
                    n_kind  = KIND_BUILD;
                    n_value = VALUE_W'(r_total);
                    if (r_err[1]) begin
                        n_status = STAT_OVERFLOW;
                    end else if (r_err[0]) begin
                        n_status = STAT_ID_RANGE;
                    end else begin
                        n_status = STAT_OK;
                    end
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_SCT_B;
                end
            end
            ST_SCT_B: begin
                if (st_out) begin
                    n_idx   = r_idx + EW'(1);
                    n_state = ST_SCT_A;
                end else begin
                    off_raddr = OW'(st_src) + OW'(1);
                    n_slot    = OW'(st_src) + OW'(1);
                    n_tgt     = st_tgt;
                    n_state   = ST_SCT_C;
                end
            end
            ST_SCT_C: begin
                // Place the target at the source's cursor and advance it.
                off_we = 1'b1;
                if (r_off_rdata < EW'(MAX_EDGES)) begin
                    adj_we = 1'b1;
                end
                n_idx   = r_idx + EW'(1);
                n_state = ST_SCT_A;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (cfg_wr && (paddr[2] == REG_MAX_ID)) begin
            n_max_id = pwdata[VID_W-1:0];
            n_built  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_max_id   <= MAX_ID_RESET;
            r_edge_cnt <= '0;
            r_err      <= '0;
            r_built    <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_max_id   <= n_max_id;
            r_edge_cnt <= n_edge_cnt;
            r_err      <= n_err;
            r_built    <= n_built;
            r_valid    <= n_valid;
        end
        r_idx    <= n_idx;
        r_vidx   <= n_vidx;
        r_slot   <= n_slot;
        r_tgt    <= n_tgt;
        r_acc    <= n_acc;
        r_total  <= n_total;
        r_rd_ok  <= n_rd_ok;
        r_rd_off <= n_rd_off;
        r_kind   <= n_kind;
        r_status <= n_status;
        r_value  <= n_value;
    end

    always_ff @(posedge i_clk) begin
        if (off_we) begin
            r_off_mem[off_waddr] <= off_wdata;
        end
        r_off_rdata <= r_off_mem[off_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            r_edge_mem[edge_waddr] <= edge_wdata;
        end
        r_edge_rdata <= r_edge_mem[edge_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            r_adj_mem[adj_waddr] <= adj_wdata;
        end
        r_adj_rdata <= r_adj_mem[adj_raddr];
    end

endmodule

// ===== src/ecsr_checker.sv =====
// Port-level checks for the edge-list to CSR builder, bound to its top level.
module ecsr_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [ecsr_pkg::MODE_W-1:0]    i_mode,
    input  logic                           i_result_valid,
    input  logic                           i_result_kind,
    input  logic [ecsr_pkg::STATUS_W-1:0]  i_status,
    input  logic [ecsr_pkg::VALUE_W-1:0]   i_value
);
    import ecsr_pkg::*;

    logic acc_word;
    assign acc_word = i_start && !i_busy;

    // A read word holds busy for its lookup and then yields its result.
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_word && (i_mode == MODE_READ)) |=> (i_busy ##1 i_result_valid))
        else $error("read word did not give its result two cycles later");

    // Clear and add finish at once and give nothing.
    a_quiet_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_word && ((i_mode == MODE_CLEAR) || (i_mode == MODE_ADD)))
        |=> (!i_busy && !i_result_valid))
        else $error("clear or add word stalled or produced a result");

    // Results never come back to back.
    a_no_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid |=> !i_result_valid)
        else $error("result strobe high for two cycles");

    a_bad_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_result_valid && (i_status == STAT_BAD_READ))
        |-> ((i_result_kind == KIND_READ) && (i_value == '0)))
        else $error("bad read status with non-zero value or wrong kind");

    a_read_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_result_valid && (i_result_kind == KIND_READ))
        |-> ((i_status == STAT_OK) || (i_status == STAT_BAD_READ)))
        else $error("read result carries a build error status");

endmodule

bind edge_list_to_csr_builder_top ecsr_checker u_ecsr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (start),
    .i_busy         (busy),
    .i_mode         (i_mode),
    .i_result_valid (o_result_valid),
    .i_result_kind  (o_result_kind),
    .i_status       (o_status),
    .i_value        (o_value)
);

// ===== bench/edge_list_to_csr_builder_checker.sv =====
// Checker for the CSR builder: watches the command, result and APB channels and compares.
module edge_list_to_csr_builder_checker #(
    parameter int VERT_CAP = 1024,
    parameter int EDGE_CAP = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [ecsr_pkg::MODE_W-1:0]    i_mode,
    input  logic [ecsr_pkg::VID_W-1:0]     i_source_vertex,
    input  logic [ecsr_pkg::VID_W-1:0]     i_target_vertex,
    input  logic [ecsr_pkg::ADDR_W-1:0]    i_read_address,
    input  logic                           i_result_valid,
    input  logic                           i_result_kind,
    input  logic [ecsr_pkg::STATUS_W-1:0]  i_status,
    input  logic [ecsr_pkg::VALUE_W-1:0]   i_value,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [ecsr_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [ecsr_pkg::PDATA_W-1:0]   i_pwdata,
    input  logic [ecsr_pkg::PDATA_W-1:0]   i_prdata,
    input  logic                           i_pready,
    output int                             o_fail_count,
    output int                             o_words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ecsr_pkg::*;

    localparam logic [1:0] ERR_ID   = 2'b01;
    localparam logic [1:0] ERR_FULL = 2'b10;

    typedef struct packed {
        logic                kind;
        t_status             status;
        logic [VALUE_W-1:0]  value;
    } csr_word_t;

    logic [VID_W-1:0]    max_id;
    logic [VID_W-1:0]    edge_src [EDGE_CAP];
    logic [VID_W-1:0]    edge_dst [EDGE_CAP];
    int unsigned         stored_n;
    logic [1:0]          err_flags;
    bit                  image_valid;
    logic [VALUE_W-1:0]  row_start [VERT_CAP+1];
    logic [VID_W-1:0]    col_target [EDGE_CAP];
    csr_word_t           csr_words_due [$];
    csr_word_t           seen_word;
    csr_word_t           due_word;
    int                  fail_total = 0;

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("%0t ns: mismatch on %s, expected %0d, got %0d", $time, what, want, got);
        fail_total++;
    endtask

    function automatic int unsigned eff_max();
        return (int'(max_id) > VERT_CAP - 1) ? VERT_CAP - 1 : max_id;
    endfunction

    function automatic void store_edge(input logic [VID_W-1:0] src,
                                       input logic [VID_W-1:0] dst);
        int unsigned m;
        m = eff_max();
        if (src > m || dst > m) begin
            err_flags |= ERR_ID;
        end else if (stored_n >= EDGE_CAP) begin
            err_flags |= ERR_FULL;
        end else begin
            edge_src[stored_n] = src;
            edge_dst[stored_n] = dst;
            stored_n++;
            image_valid = 1'b0;
        end
    endfunction

    // Counting sort: degrees, exclusive prefix, stable scatter.
    function automatic csr_word_t build_csr();
        int unsigned m;
        int unsigned cursor [VERT_CAP];
        csr_word_t   word;
        m = eff_max();
        foreach (row_start[v]) row_start[v] = '0;
        for (int i = 0; i < stored_n; i++) begin
            if (edge_src[i] > m || edge_dst[i] > m)
                err_flags |= ERR_ID;
            else
                row_start[int'(edge_src[i]) + 1] = row_start[int'(edge_src[i]) + 1] + 1'b1;
        end
        for (int v = 0; v <= m; v++) row_start[v+1] = row_start[v+1] + row_start[v];
        for (int v = 0; v <= m; v++) cursor[v] = row_start[v];
        for (int i = 0; i < stored_n; i++) begin
            if (edge_src[i] <= m && edge_dst[i] <= m) begin
                col_target[cursor[edge_src[i]]] = edge_dst[i];
                cursor[edge_src[i]]++;
            end
        end
        image_valid = 1'b1;
        word.kind   = KIND_BUILD;
        word.status = (err_flags & ERR_FULL) ? STAT_OVERFLOW :
                      (err_flags & ERR_ID)   ? STAT_ID_RANGE : STAT_OK;
        word.value  = row_start[m+1];
        return word;
    endfunction

    function automatic csr_word_t read_csr(input logic [ADDR_W-1:0] addr);
        int unsigned m;
        int unsigned k;
        csr_word_t   word;
        m = eff_max();
        word.kind   = KIND_READ;
        word.status = STAT_BAD_READ;
        word.value  = '0;
        if (image_valid) begin
            if (addr <= m + 1) begin
                word.status = STAT_OK;
                word.value  = row_start[addr];
            end else begin
                k = addr - (m + 2);
                if (k < row_start[m+1] && k < EDGE_CAP) begin
                    word.status = STAT_OK;
                    word.value  = VALUE_W'(col_target[k]);
                end
            end
        end
        return word;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_id      = MAX_ID_RESET;
            stored_n    = 0;
            err_flags   = '0;
            image_valid = 1'b0;
            foreach (row_start[v]) row_start[v] = '0;
            csr_words_due.delete();
        end else begin
            // Compare the result word first; it always belongs to an older command.
            if (i_result_valid) begin
                seen_word.kind   = i_result_kind;
                seen_word.status = t_status'(i_status);
                seen_word.value  = i_value;
                if (csr_words_due.size() == 0) begin
                    report_mismatch("unexpected result word (value)", 0, i_value);
                end else begin
                    due_word = csr_words_due.pop_front();
                    if (seen_word.kind != due_word.kind)
                        report_mismatch("result_kind", due_word.kind, seen_word.kind);
                    if (seen_word.status != due_word.status)
                        report_mismatch("status", due_word.status, seen_word.status);
                    if (seen_word.value != due_word.value)
                        report_mismatch("value", due_word.value, seen_word.value);
                end
            end

            if (i_psel && i_penable && i_pready && i_paddr[PADDR_W-1:2] == REG_MAX_ID) begin
                if (i_pwrite) begin
                    max_id      = i_pwdata[VID_W-1:0];
                    image_valid = 1'b0;
                end else if (i_prdata != PDATA_W'(max_id)) begin
                    report_mismatch("max_vertex_id readback", max_id, i_prdata);
                end
            end

            if (i_start && !i_busy) begin
                case (t_mode'(i_mode))
                    MODE_CLEAR: begin
                        stored_n    = 0;
                        err_flags   = '0;
                        image_valid = 1'b0;
                    end
                    MODE_ADD:   store_edge(i_source_vertex, i_target_vertex);
                    MODE_BUILD: csr_words_due.push_back(build_csr());
                    MODE_READ:  csr_words_due.push_back(read_csr(i_read_address));
                    default: ;
                endcase
            end
        end
        o_fail_count    <= fail_total;
        o_words_pending <= csr_words_due.size();
    end

endmodule

// ===== bench/edge_list_to_csr_builder_top_tb.sv =====
// Testbench top for the CSR builder: clock, reset, command and APB stimulus, verdict.
module edge_list_to_csr_builder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ecsr_pkg::*;

    localparam int VERT_CAP  = 1024;
    localparam int EDGE_CAP  = 4096;
    localparam int ITEM_GOAL = 1350;
    // Watchdog cycle limit; this is many times the slowest run.
    localparam int LIMIT     = 4_000_000;
    localparam logic [PADDR_W-1:0] MAX_ID_ADDR = {REG_MAX_ID, 2'b00};

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  start           = 1'b0;
    logic                  busy;
    logic [MODE_W-1:0]     i_mode          = '0;
    logic [VID_W-1:0]      i_source_vertex = '0;
    logic [VID_W-1:0]      i_target_vertex = '0;
    logic [ADDR_W-1:0]     i_read_address  = '0;
    logic                  o_result_valid;
    logic                  o_result_kind;
    logic [STATUS_W-1:0]   o_status;
    logic [VALUE_W-1:0]    o_value;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [PADDR_W-1:0]    paddr           = '0;
    logic [PDATA_W-1:0]    pwdata          = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    int                    fail_count;
    int                    words_pending;
    int                    cycle_n   = 0;
    int                    item_n    = 0;
    int                    cfg_n     = 0;
    int                    mode_count [4] = '{0, 0, 0, 0};
    logic [VID_W-1:0]      cur_max   = MAX_ID_RESET;

    edge_list_to_csr_builder_top #(
        .MAX_VERTICES (VERT_CAP),
        .MAX_EDGES    (EDGE_CAP)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_source_vertex (i_source_vertex),
        .i_target_vertex (i_target_vertex),
        .i_read_address  (i_read_address),
        .o_result_valid  (o_result_valid),
        .o_result_kind   (o_result_kind),
        .o_status        (o_status),
        .o_value         (o_value),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    edge_list_to_csr_builder_checker #(
        .VERT_CAP (VERT_CAP),
        .EDGE_CAP (EDGE_CAP)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_mode          (i_mode),
        .i_source_vertex (i_source_vertex),
        .i_target_vertex (i_target_vertex),
        .i_read_address  (i_read_address),
        .i_result_valid  (o_result_valid),
        .i_result_kind   (o_result_kind),
        .i_status        (o_status),
        .i_value         (o_value),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_prdata        (prdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result word ends up here.
    always @(posedge i_clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n >= LIMIT) begin
            $display("timeout after %0d cycles with %0d result words outstanding",
                     cycle_n, words_pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one command word and hold it until the block takes it. Idle gaps go in
    // front of the word, except across a steady stretch in the middle of the run.
    task automatic issue(input t_mode md, input logic [VID_W-1:0] src,
                         input logic [VID_W-1:0] dst, input logic [ADDR_W-1:0] addr);
        int gap;
        gap = 0;
        if (!(item_n >= 600 && item_n < 900) && $urandom_range(99) < 11)
            gap = $urandom_range(1, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_mode          <= md;
        i_source_vertex <= src;
        i_target_vertex <= dst;
        i_read_address  <= addr;
        do @(posedge i_clk); while (busy);
        item_n++;
        mode_count[md]++;
    endtask

    // Drop start and hold off until every result word is back and the block is idle;
    // the extra cycles cover a trailing clear or add, which gives no word.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_access(input bit wr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MAX_ID_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write max_vertex_id while idle, with junk in the unused upper bits, then read
    // it back so the checker can compare prdata.
    task automatic set_max_id(input logic [VID_W-1:0] v);
        logic [PDATA_W-1:0] word;
        settle();
        word = $urandom();
        word[VID_W-1:0] = v;
        apb_access(1'b1, word);
        apb_access(1'b0, '0);
        cur_max = v;
        cfg_n++;
    endtask

    // Mostly an id inside the current graph, now and then any 10-bit id.
    function automatic logic [VID_W-1:0] pick_id();
        if ($urandom_range(99) < 10)
            return VID_W'($urandom());
        return VID_W'($urandom_range(0, cur_max));
    endfunction

    initial begin
        int n_adds;
        logic [ADDR_W-1:0] addr;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full-size graph straight out of reset.
        issue(MODE_READ,  0, 0, 0);           // read before any build: bad read
        issue(MODE_BUILD, 0, 0, 0);           // empty graph
        issue(MODE_READ,  0, 0, 1024);        // last offset word
        issue(MODE_READ,  0, 0, 1025);        // no target words yet
        issue(MODE_ADD,   1023, 0, 0);
        issue(MODE_ADD,   0, 1023, 0);
        issue(MODE_ADD,   1023, 5, 0);
        issue(MODE_ADD,   0, 7, 0);           // second target of vertex 0 keeps its order
        issue(MODE_BUILD, 0, 0, 0);
        issue(MODE_READ,  0, 0, 1);
        issue(MODE_READ,  0, 0, 1024);
        issue(MODE_READ,  0, 0, 1025);
        issue(MODE_READ,  0, 0, 1028);        // last target word
        issue(MODE_READ,  0, 0, 1029);        // just past the image
        issue(MODE_READ,  0, 0, 13'h1FFF);
        issue(MODE_ADD,   3, 3, 0);           // add after build spoils the image
        issue(MODE_READ,  0, 0, 0);
        issue(MODE_CLEAR, 0, 0, 0);
        issue(MODE_BUILD, 0, 0, 0);

        // Smallest graph: ids above zero are dropped and flagged.
        set_max_id(0);
        issue(MODE_ADD,   0, 0, 0);
        issue(MODE_ADD,   1, 0, 0);
        issue(MODE_BUILD, 0, 0, 0);
        issue(MODE_READ,  0, 0, 2);
        issue(MODE_READ,  0, 0, 3);

        // Shrink the graph under stored edges: the build recounts and flags them.
        set_max_id(1023);
        issue(MODE_CLEAR, 0, 0, 0);
        issue(MODE_ADD,   1000, 2, 0);
        issue(MODE_ADD,   2, 3, 0);
        issue(MODE_ADD,   4, 900, 0);
        set_max_id(10);
        issue(MODE_BUILD, 0, 0, 0);
        issue(MODE_READ,  0, 0, 12);

        // Fill the edge store to the brim, then push past it.
        set_max_id(63);
        issue(MODE_CLEAR, 0, 0, 0);
        repeat (EDGE_CAP) issue(MODE_ADD, pick_id() & 10'h3F, pick_id() & 10'h3F, 0);
        issue(MODE_BUILD, 0, 0, 0);
        issue(MODE_READ,  0, 0, 64);
        issue(MODE_READ,  0, 0, ADDR_W'(65 + EDGE_CAP - 1));
        issue(MODE_READ,  0, 0, ADDR_W'(65 + EDGE_CAP));
        issue(MODE_ADD,   5, 5, 0);           // dropped on overflow, image stays valid
        issue(MODE_READ,  0, 0, 0);
        issue(MODE_ADD,   700, 1, 0);         // id error as well: overflow wins
        issue(MODE_BUILD, 0, 0, 0);
        issue(MODE_CLEAR, 0, 0, 0);

        // Random part: mostly clear / add / build / read sequences, some noise.
        while (item_n < ITEM_GOAL + EDGE_CAP) begin
            case ($urandom_range(24))
                0:       set_max_id(0);
                1:       set_max_id(1023);
                2, 3:    set_max_id(VID_W'($urandom_range(0, 1023)));
                4, 5:    set_max_id(VID_W'($urandom_range(1, 31)));
                6:       settle();
                default: ;
            endcase
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(99) < 80)
                    issue(MODE_CLEAR, VID_W'($urandom()), VID_W'($urandom()),
                          ADDR_W'($urandom()));
                n_adds = $urandom_range(0, 30);
                repeat (n_adds) issue(MODE_ADD, pick_id(), pick_id(), ADDR_W'($urandom()));
                issue(MODE_BUILD, VID_W'($urandom()), VID_W'($urandom()),
                      ADDR_W'($urandom()));
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(99) < 15)
                        addr = ADDR_W'($urandom());
                    else
                        addr = ADDR_W'($urandom_range(0, int'(cur_max) + 2 + n_adds));
                    issue(MODE_READ, VID_W'($urandom()), VID_W'($urandom()), addr);
                end
            end else begin
                repeat ($urandom_range(5, 15))
                    issue(t_mode'($urandom_range(3)), VID_W'($urandom()),
                          VID_W'($urandom()), ADDR_W'($urandom()));
            end
        end

        // Drain, then let the block run out before the verdict.
        settle();
        repeat (16) @(posedge i_clk);

        $display("Ran %0d command words (%0d clear, %0d add, %0d build, %0d read) over %0d register settings.",
                 item_n, mode_count[MODE_CLEAR], mode_count[MODE_ADD],
                 mode_count[MODE_BUILD], mode_count[MODE_READ], cfg_n);
        $display("Took in empty and one-vertex graphs, shrunk graphs and an overfilled edge store.");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
